// ----- src/bcd_digit_scan_display_unit_assert.svh -----
// assertion macros for the bcd digit scan display unit
`ifndef BCD_DIGIT_SCAN_DISPLAY_UNIT_ASSERT_SVH
`define BCD_DIGIT_SCAN_DISPLAY_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define BDSD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bcd digit scan check failed");

// checked on every clock edge, reset included
`define BDSD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("bcd digit scan reset check failed");

`endif

// ----- src/bdsd_pkg.sv -----
// shared constants and types for the bcd digit scan display unit
package bdsd_pkg;

    localparam int NUM_DIGITS  = 6;
    localparam int VALUE_W     = 20;
    localparam int BCD_W       = 4;
    localparam int EN_W        = 6;
    localparam int POS_W       = 3;
    localparam int DIGITS_W    = NUM_DIGITS * BCD_W;
    localparam int CNT_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every x below 2**22
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(838861);

    typedef struct packed {
        logic [VALUE_W-1:0]  rest;
        logic [DIGITS_W-1:0] digits;
    } bdsd_stage_t;

endpackage

// ----- src/bcd_digit_scan_display_unit.sv -----
// top level of the bcd digit scan display unit
//
// input channel: in_valid / in_ready with a 20-bit binary value
// output channel: out_valid / out_ready, one beat per decimal digit, units
// digit first: bcd_digit for the segment decoder, one-hot digit_enable,
// position and last on the sixth digit; higher decimal digits are dropped
// a row of six identical digit cells strips one digit per cell with a
// reciprocal multiply by one tenth; a scanner then shifts the digits out
// the value passes through the six cell registers and the scanner register before its
// units digit beat; the later digits follow one beat each while out_ready stays high
// the output rate is set by the single output channel carrying one digit per beat, and
// the scanner takes the next value on its last digit beat; the cell row accepts a new
// value each cycle while it has room, so up to six values wait in the cells
// reset empties the cells and the scanner; no output beat is pending
// when the receiver stalls, the current digit holds and the cells fill
// up behind the scanner, then in_ready drops until the scanner moves on
`include "bcd_digit_scan_display_unit_assert.svh"

module bcd_digit_scan_display_unit
    import bdsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BCD_W-1:0]   bcd_digit,
    output logic [EN_W-1:0]    digit_enable,
    output logic [POS_W-1:0]   position,
    output logic               last
);

    bdsd_stage_t           link_data  [NUM_DIGITS+1];
    logic [NUM_DIGITS:0]   link_valid;
    logic [NUM_DIGITS:0]   link_ready;

    assign link_data[0].rest   = value;
    assign link_data[0].digits = '0;
    assign link_valid[0]       = in_valid;
    assign in_ready            = link_ready[0];

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        bdsd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    bdsd_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (link_valid[NUM_DIGITS]),
        .in_ready     (link_ready[NUM_DIGITS]),
        .in_digits    (link_data[NUM_DIGITS].digits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bcd_digit    (bcd_digit),
        .digit_enable (digit_enable),
        .position     (position),
        .last         (last)
    );

    `BDSD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)
    `BDSD_ASSERT(a_digits_continue, out_valid && out_ready && !last |=> out_valid)
    `BDSD_ASSERT(a_position_steps, out_valid && out_ready && !last |=> position == $past(position) + POS_W'(1))
    `BDSD_ASSERT(a_last_position, out_valid && last |-> position == POS_W'(NUM_DIGITS - 1))

endmodule

// ----- src/bdsd_cell.sv -----
// one digit cell: peels the lowest decimal digit off the value and passes the rest on
module bdsd_cell
    import bdsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bdsd_stage_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output bdsd_stage_t out_data
);

    logic                          valid_reg;
    logic                          valid_next;
    bdsd_stage_t                   data_reg;
    bdsd_stage_t                   data_next;
    logic [VALUE_W+RECIP_W-1:0]    prod;
    logic [VALUE_W-1:0]            quot;
    logic [VALUE_W-1:0]            rem;
    logic [DIGITS_W+BCD_W-1:0]     digit_cat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        prod      = VALUE_W'(in_data.rest) * (VALUE_W+RECIP_W)'(RECIP);
        quot      = VALUE_W'(prod >> RECIP_SHIFT);
        rem       = in_data.rest - (quot << 3) - (quot << 1);
        // new digit enters at the top, older digits move down one slot
        digit_cat = {rem[BCD_W-1:0], in_data.digits};
        data_next.rest   = quot;
        data_next.digits = digit_cat[DIGITS_W+BCD_W-1:BCD_W];
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- src/bdsd_scan.sv -----
// digit scanner: sends the converted digits one beat each, units digit first
module bdsd_scan
    import bdsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DIGITS_W-1:0] in_digits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BCD_W-1:0]    bcd_digit,
    output logic [EN_W-1:0]     digit_enable,
    output logic [POS_W-1:0]    position,
    output logic                last
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [DIGITS_W-1:0]       shift_reg;
    logic [DIGITS_W-1:0]       shift_next;
    logic [EN_W-1:0]           enable_reg;
    logic [EN_W-1:0]           enable_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [DIGITS_W+BCD_W-1:0] shift_cat;
    logic                      last_w;
    logic                      beat;
    logic                      load;

    assign last_w       = (count_reg == CNT_W'(NUM_DIGITS - 1));
    assign beat         = busy_reg && out_ready;
    assign in_ready     = !busy_reg || (out_ready && last_w);
    assign load         = in_ready && in_valid;

    assign out_valid    = busy_reg;
    assign bcd_digit    = shift_reg[BCD_W-1:0];
    assign digit_enable = enable_reg;
    assign position     = POS_W'(count_reg);
    assign last         = last_w;

    always_comb
    begin
        shift_cat   = {BCD_W'(0), shift_reg};
        shift_next  = shift_reg;
        enable_next = enable_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        if (load)
        begin
            shift_next  = in_digits;
            enable_next = EN_W'(1);
            count_next  = '0;
            busy_next   = 1'b1;
        end
        else if (beat)
        begin
            shift_next  = shift_cat[DIGITS_W+BCD_W-1:BCD_W];
            enable_next = enable_reg << 1;
            count_next  = count_reg + CNT_W'(1);
            if (last_w)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        enable_reg <= enable_next;
    end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the bcd digit scan display unit
module tb_top;
    import bdsd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_VALUES = 410;
    localparam int HOLDOFF_LEN   = 80;
    localparam int DRAIN_CYCLES  = 24;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 20'd999999;

    typedef struct {
        logic [BCD_W-1:0] bcd;
        logic [EN_W-1:0]  en;
        logic [POS_W-1:0] pos;
        logic             last;
    } digit_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BCD_W-1:0]   bcd_digit;
    logic [EN_W-1:0]    digit_enable;
    logic [POS_W-1:0]   position;
    logic               last;

    logic [VALUE_W-1:0] pending_values[$];
    digit_beat_t        expected_digits[$];
    digit_beat_t        exp_beat;
    int                 error_count = 0;
    int                 digit_beats = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 stall_cycle = 0;
    int                 holdoff_left = 0;
    int                 holdoffs_done = 0;

    bcd_digit_scan_display_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bcd_digit    (bcd_digit),
        .digit_enable (digit_enable),
        .position     (position),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // split a value into decimal digit beats, units first
    function automatic void predict_digits(input logic [VALUE_W-1:0] v);
        digit_beat_t beat;
        int unsigned rest;
        rest = v;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            beat.bcd  = BCD_W'(rest % 10);
            beat.en   = (k < EN_W) ? (EN_W'(1) << k) : '0;
            beat.pos  = POS_W'(k);
            beat.last = (k == NUM_DIGITS - 1);
            rest      = rest / 10;
            expected_digits.push_back(beat);
        end
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            value      <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0 || pending_values.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                value    <= pending_values.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // receiver: stall pattern steps through four modes in turn, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            stall_cycle   = 0;
            holdoff_left  = 0;
            holdoffs_done = 0;
        end
        else
        begin
            stall_cycle++;
            if (holdoff_left == 0 && ((holdoffs_done == 0 && digit_beats >= 600) ||
                                      (holdoffs_done == 1 && digit_beats >= 1500)))
            begin
                holdoff_left = HOLDOFF_LEN;
                holdoffs_done++;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((stall_cycle / 40) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= (stall_cycle % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // monitor: record accepted values, check digit beats in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_digits(value);
            if (out_valid && out_ready)
            begin
                digit_beats <= digit_beats + 1;
                if (expected_digits.size() == 0)
                begin
                    $display("%0t: unexpected digit beat bcd=%0d en=%b pos=%0d last=%b",
                             $time, bcd_digit, digit_enable, position, last);
                    error_count++;
                end
                else
                begin
                    exp_beat = expected_digits.pop_front();
                    if (bcd_digit !== exp_beat.bcd)
                    begin
                        $display("%0t: bcd_digit expected %0d actual %0d",
                                 $time, exp_beat.bcd, bcd_digit);
                        error_count++;
                    end
                    if (digit_enable !== exp_beat.en)
                    begin
                        $display("%0t: digit_enable expected %b actual %b",
                                 $time, exp_beat.en, digit_enable);
                        error_count++;
                    end
                    if (position !== exp_beat.pos)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, exp_beat.pos, position);
                        error_count++;
                    end
                    if (last !== exp_beat.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_beat.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        // extremes, values past six digits, alternating bit patterns
        pending_values.push_back(20'd0);
        pending_values.push_back(VALUE_MAX);
        pending_values.push_back(20'hFFFFF);
        pending_values.push_back(20'd1000000);
        pending_values.push_back(20'd1000001);
        pending_values.push_back(20'd123456);
        pending_values.push_back(20'd654321);
        pending_values.push_back(20'd1);
        pending_values.push_back(20'd9);
        pending_values.push_back(20'd10);
        pending_values.push_back(20'd99999);
        pending_values.push_back(20'd100000);
        pending_values.push_back(20'd909090);
        pending_values.push_back(20'd524288);
        pending_values.push_back(20'hAAAAA);
        pending_values.push_back(20'h55555);
        pending_values.push_back(20'd1048570);
        pending_values.push_back(20'd500000);
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                pending_values.push_back(VALUE_W'($urandom_range(0, 999999)));
            else if (pick < 8)
                pending_values.push_back(VALUE_W'($urandom_range(0, 2 ** VALUE_W - 1)));
            else
                pending_values.push_back(VALUE_W'($urandom_range(0, 999)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_values.size() == 0 && !in_valid);
        wait (expected_digits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_digits.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+src
src/bdsd_pkg.sv
src/bdsd_cell.sv
src/bdsd_scan.sv
src/bcd_digit_scan_display_unit.sv
tb/tb_top.sv
